// ===== src/mcb_pkg.sv =====
// ----------------------------------------------------------------------------
// mcb_pkg: shared types, constants and control store of the maze carver
// Field layouts of the input and result beats, microcode word format and the
// read-only program that sequences every operation.
// ----------------------------------------------------------------------------
package mcb_pkg;

	localparam int MAX_SIDE    = 64;
	localparam int STACK_DEPTH = 1024;
	localparam int ROW_AW      = $clog2(MAX_SIDE);
	localparam int DEPTH_W     = $clog2(STACK_DEPTH);
	localparam int COORD_W     = 6;
	localparam int DEPTH_OUT_W = 10;
	localparam int CFG_IDX_W   = 2;

	typedef logic [COORD_W-1:0]   coord_t;
	typedef logic [MAX_SIDE-1:0]  row_t;
	typedef logic [DEPTH_W-1:0]   depth_t;
	typedef logic [2*COORD_W-1:0] stk_entry_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [1:0] direction;
		coord_t     query_row;
		coord_t     query_col;
	} in_t;

	typedef struct packed {
		logic [2:0]             action;
		coord_t                 cur_row;
		coord_t                 cur_col;
		coord_t                 wall_row;
		coord_t                 wall_col;
		logic [DEPTH_OUT_W-1:0] stack_depth;
		logic                   done_res;
		logic                   cell_open;
	} out_t;

	typedef enum logic [1:0] {
		OP_RESTART = 2'd0,
		OP_STEP    = 2'd1,
		OP_READ    = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		DIR_LEFT  = 2'd0,
		DIR_UP    = 2'd1,
		DIR_RIGHT = 2'd2,
		DIR_DOWN  = 2'd3
	} dir_t;

	typedef enum logic [2:0] {
		ACT_CARVED      = 3'd0,
		ACT_BACKTRACKED = 3'd1,
		ACT_STAYED      = 3'd2,
		ACT_RESTARTED   = 3'd3,
		ACT_CELL_READ   = 3'd4
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH     = 2'd0,
		CFG_HEIGHT    = 2'd1,
		CFG_START_ROW = 2'd2,
		CFG_START_COL = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MEM_NONE,
		MEM_READ,
		MEM_WRITE,
		MEM_RESTART
	} mem_op_t;

	typedef enum logic [2:0] {
		ROW_TGT,
		ROW_WALL,
		ROW_CUR,
		ROW_UP,
		ROW_DOWN,
		ROW_QUERY,
		ROW_START
	} row_sel_t;

	typedef enum logic [1:0] {
		COL_TGT,
		COL_WALL,
		COL_START
	} col_sel_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_LOAD,
		DP_CAP_LR,
		DP_CAP_MID,
		DP_RESTART,
		DP_PUSH,
		DP_POP_RD,
		DP_POP_LD,
		DP_SET_DONE
	} dp_op_t;

	typedef enum logic [2:0] {
		JMP_NEXT,
		JMP_DISPATCH,
		JMP_CARVE,
		JMP_NOT_ALL,
		JMP_DEPTH_ZERO
	} jmp_t;

	typedef enum logic [4:0] {
		U_IDLE,
		U_ST_RDT,
		U_ST_TEST,
		U_NB_RDC,
		U_NB_RDU,
		U_NB_RDD,
		U_NB_TEST,
		U_BT_TEST,
		U_BT_RD,
		U_BT_LD,
		U_BT_ZERO,
		U_STAY,
		U_CV_WT,
		U_CV_RDW,
		U_CV_WW,
		U_RESTART,
		U_RD_Q,
		U_RD_OUT
	} upc_t;

	typedef struct packed {
		mem_op_t  mem_op;
		row_sel_t row_sel;
		col_sel_t col_sel;
		dp_op_t   dp_op;
		jmp_t     jmp;
		upc_t     target;
		logic     finish;
		action_t  res;
	} uword_t;

	typedef struct packed {
		mem_op_t kind;
		coord_t  row;
		coord_t  col;
	} cmap_req_t;

	typedef struct packed {
		logic carve;
		logic nb_all;
		logic depth_zero;
		logic done;
	} cond_t;

	function automatic logic in_side(coord_t v);
		return 9'(v) < 9'(MAX_SIDE);
	endfunction

	function automatic logic bit_of(row_t w, coord_t c);
		return in_side(c) ? w[ROW_AW'(c)] : 1'b0;
	endfunction

	function automatic row_t onehot(coord_t c);
		return row_t'(1'b1) << ROW_AW'(c);
	endfunction

	function automatic uword_t mk(mem_op_t m, row_sel_t r, col_sel_t c, dp_op_t d,
		jmp_t j, upc_t t, logic f, action_t a);
		uword_t w;
		w.mem_op  = m;
		w.row_sel = r;
		w.col_sel = c;
		w.dp_op   = d;
		w.jmp     = j;
		w.target  = t;
		w.finish  = f;
		w.res     = a;
		return w;
	endfunction

	// Control store. A word with finish set returns to U_IDLE once its beat
	// is registered; its jump field is not used.
	function automatic uword_t ucode_rom(upc_t a);
		uword_t w;
		w = mk(MEM_NONE, ROW_TGT, COL_TGT, DP_LOAD, JMP_DISPATCH, U_IDLE, 1'b0,
			ACT_STAYED);
		unique case (a)
			U_IDLE:    w = mk(MEM_NONE, ROW_TGT, COL_TGT, DP_LOAD, JMP_DISPATCH,
				U_IDLE, 1'b0, ACT_STAYED);
			U_ST_RDT:  w = mk(MEM_READ, ROW_TGT, COL_TGT, DP_NONE, JMP_NEXT,
				U_IDLE, 1'b0, ACT_STAYED);
			U_ST_TEST: w = mk(MEM_NONE, ROW_TGT, COL_TGT, DP_NONE, JMP_CARVE,
				U_CV_WT, 1'b0, ACT_STAYED);
			U_NB_RDC:  w = mk(MEM_READ, ROW_CUR, COL_TGT, DP_NONE, JMP_NEXT,
				U_IDLE, 1'b0, ACT_STAYED);
			U_NB_RDU:  w = mk(MEM_READ, ROW_UP, COL_TGT, DP_CAP_LR, JMP_NEXT,
				U_IDLE, 1'b0, ACT_STAYED);
			U_NB_RDD:  w = mk(MEM_READ, ROW_DOWN, COL_TGT, DP_CAP_MID, JMP_NEXT,
				U_IDLE, 1'b0, ACT_STAYED);
			U_NB_TEST: w = mk(MEM_NONE, ROW_TGT, COL_TGT, DP_NONE, JMP_NOT_ALL,
				U_STAY, 1'b0, ACT_STAYED);
			U_BT_TEST: w = mk(MEM_NONE, ROW_TGT, COL_TGT, DP_NONE, JMP_DEPTH_ZERO,
				U_BT_ZERO, 1'b0, ACT_STAYED);
			U_BT_RD:   w = mk(MEM_NONE, ROW_TGT, COL_TGT, DP_POP_RD, JMP_NEXT,
				U_IDLE, 1'b0, ACT_STAYED);
			U_BT_LD:   w = mk(MEM_NONE, ROW_TGT, COL_TGT, DP_POP_LD, JMP_NEXT,
				U_IDLE, 1'b1, ACT_BACKTRACKED);
			U_BT_ZERO: w = mk(MEM_NONE, ROW_TGT, COL_TGT, DP_SET_DONE, JMP_NEXT,
				U_IDLE, 1'b1, ACT_BACKTRACKED);
			U_STAY:    w = mk(MEM_NONE, ROW_TGT, COL_TGT, DP_NONE, JMP_NEXT,
				U_IDLE, 1'b1, ACT_STAYED);
			U_CV_WT:   w = mk(MEM_WRITE, ROW_TGT, COL_TGT, DP_NONE, JMP_NEXT,
				U_IDLE, 1'b0, ACT_STAYED);
			U_CV_RDW:  w = mk(MEM_READ, ROW_WALL, COL_WALL, DP_NONE, JMP_NEXT,
				U_IDLE, 1'b0, ACT_STAYED);
			U_CV_WW:   w = mk(MEM_WRITE, ROW_WALL, COL_WALL, DP_PUSH, JMP_NEXT,
				U_IDLE, 1'b1, ACT_CARVED);
			U_RESTART: w = mk(MEM_RESTART, ROW_START, COL_START, DP_RESTART, JMP_NEXT,
				U_IDLE, 1'b1, ACT_RESTARTED);
			U_RD_Q:    w = mk(MEM_READ, ROW_QUERY, COL_TGT, DP_NONE, JMP_NEXT,
				U_IDLE, 1'b0, ACT_STAYED);
			U_RD_OUT:  w = mk(MEM_NONE, ROW_TGT, COL_TGT, DP_NONE, JMP_NEXT,
				U_IDLE, 1'b1, ACT_CELL_READ);
			default:   w = mk(MEM_NONE, ROW_TGT, COL_TGT, DP_LOAD, JMP_DISPATCH,
				U_IDLE, 1'b0, ACT_STAYED);
		endcase
		return w;
	endfunction

endpackage

// ===== src/maze_carver_backtracking_core.sv =====
// ----------------------------------------------------------------------------
// maze_carver_backtracking_core: depth-first maze carver with backtrack stack
// Usage:
//   The input channel (in_valid/in_stall/in_data) takes one operation per beat:
//   restart, walk step or cell read. Every accepted beat yields exactly one
//   result beat on out_valid/out_stall/out_data, in order.
//   Grid size and start cell are set on the cfg channel (cfg_ready is always
//   high); write them only while no operation is in flight.
//   A microcoded sequencer drives one access per cycle to the single-port
//   row bitmap, so an operation lasts as long as its program: restart, unused
//   operation and stayed-after-done are shortest, then cell read, carving
//   step, dead-end stay and backtrack (shorter when the stack is already empty).
//   The result is registered at the end of the last step, and the next
//   operation can be accepted in the cycle after it.
//   Reset walls the whole grid through per-row valid flops, leaves the
//   walker at (1,1) with depth zero and the walk flagged as done; there is no
//   clearing pass. A restart clears the grid the same way.
//   While the receiver stalls, the result beat holds and the sequencer waits
//   in its last step, so at most one more operation is taken meanwhile.
// ----------------------------------------------------------------------------
module maze_carver_backtracking_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  mcb_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output mcb_pkg::out_t                 out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mcb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  mcb_pkg::coord_t               cfg_data
);
	import mcb_pkg::*;

	uword_t    ctrl;
	logic      en;
	cond_t     cond;
	cmap_req_t cmap_req;
	row_t      rd_word;

	mcb_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_data.operation),
		.cond     (cond),
		.out_busy (out_valid && out_stall),
		.ctrl     (ctrl),
		.en       (en),
		.in_stall (in_stall)
	);

	mcb_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.en        (en),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.rd_word   (rd_word),
		.cmap_req  (cmap_req),
		.cond      (cond),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	mcb_cell_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (cmap_req),
		.rd_word (rd_word)
	);

endmodule

// ===== src/mcb_cell_map.sv =====
// ----------------------------------------------------------------------------
// mcb_cell_map: open/wall bitmap of the maze
// Single-port row memory, one row per access, with a valid flop per row so
// that a restart walls the whole grid without a clearing pass.
// ----------------------------------------------------------------------------
module mcb_cell_map (
	input  logic              clk,
	input  logic              arst_n,
	input  mcb_pkg::cmap_req_t req,
	output mcb_pkg::row_t     rd_word
);
	import mcb_pkg::*;

	row_t              mem [MAX_SIDE];
	logic [MAX_SIDE-1:0] valid_q;
	row_t              rd_q;
	logic [ROW_AW-1:0] idx;
	logic              hit_row;
	logic              hit_cell;
	logic              wr_en;
	row_t              wdata;

	assign idx      = ROW_AW'(req.row);
	assign hit_row  = in_side(req.row);
	assign hit_cell = hit_row && in_side(req.col);
	assign wr_en    = ((req.kind == MEM_WRITE) || (req.kind == MEM_RESTART)) && hit_cell;

	// A write merges its bit into the row fetched by the preceding read.
	assign wdata = (req.kind == MEM_RESTART) ? onehot(req.col) : (rd_q | onehot(req.col));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.kind == MEM_RESTART) begin
			valid_q <= hit_cell ? onehot(req.row) : '0;
		end else if (wr_en) begin
			valid_q[idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.kind == MEM_READ) begin
			rd_q <= (hit_row && valid_q[idx]) ? mem[idx] : '0;
		end
	end

	assign rd_word = rd_q;

endmodule

// ===== src/mcb_sequencer.sv =====
// ----------------------------------------------------------------------------
// mcb_sequencer: micro-program counter and control store
// Fetches one control word per cycle unless a stalled beat holds it,
// dispatches on the accepted operation and branches on datapath flags.
// ----------------------------------------------------------------------------
module mcb_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [1:0]      in_op,
	input  mcb_pkg::cond_t  cond,
	input  logic            out_busy,
	output mcb_pkg::uword_t ctrl,
	output logic            en,
	output logic            in_stall
);
	import mcb_pkg::*;

	upc_t   upc_q;
	upc_t   upc_d;
	uword_t uw;
	upc_t   upc_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

	always_comb begin
		uw       = ucode_rom(upc_q);
		upc_inc  = upc_t'(upc_q + 5'd1);
		// A finishing word waits while the previous beat is still held.
		en       = !(uw.finish && out_busy);
		in_stall = (upc_q != U_IDLE);
		upc_d    = upc_q;
		if (!en) begin
			upc_d = upc_q;
		end else if (uw.finish) begin
			upc_d = U_IDLE;
		end else begin
			unique case (uw.jmp)
				JMP_NEXT:       upc_d = upc_inc;
				JMP_DISPATCH: begin
					if (!in_valid) begin
						upc_d = U_IDLE;
					end else begin
						unique case (in_op)
							OP_RESTART: upc_d = U_RESTART;
							OP_STEP:    upc_d = cond.done ? U_STAY : U_ST_RDT;
							OP_READ:    upc_d = U_RD_Q;
							default:    upc_d = U_STAY;
						endcase
					end
				end
				JMP_CARVE:      upc_d = cond.carve ? uw.target : upc_inc;
				JMP_NOT_ALL:    upc_d = !cond.nb_all ? uw.target : upc_inc;
				JMP_DEPTH_ZERO: upc_d = cond.depth_zero ? uw.target : upc_inc;
				default:        upc_d = U_IDLE;
			endcase
		end
		ctrl = uw;
	end

endmodule

// ===== src/mcb_datapath.sv =====
// ----------------------------------------------------------------------------
// mcb_datapath: walker, stack and result datapath
// Holds configuration from the cfg channel, and walker position, depth and
// done flag, backtrack stack memory and output beat under the control word.
// ----------------------------------------------------------------------------
module mcb_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mcb_pkg::uword_t                  ctrl,
	input  logic                             en,
	input  mcb_pkg::in_t                     in_data,
	input  logic                             cfg_valid,
	input  logic [mcb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  mcb_pkg::coord_t                  cfg_data,
	output logic                             cfg_ready,
	input  mcb_pkg::row_t                    rd_word,
	output mcb_pkg::cmap_req_t               cmap_req,
	output mcb_pkg::cond_t                   cond,
	input  logic                             out_stall,
	output logic                             out_valid,
	output mcb_pkg::out_t                    out_data
);
	import mcb_pkg::*;

	coord_t     width_q, height_q, start_row_q, start_col_q;
	coord_t     walker_row_q, walker_col_q, walker_row_d, walker_col_d;
	depth_t     depth_q, depth_d;
	logic       done_q, done_d;
	coord_t     tgt_row_q, tgt_col_q, tgt_row_d, tgt_col_d;
	coord_t     qrow_q, qcol_q, qrow_d, qcol_d;
	logic       all_q, all_d;
	coord_t     nrow, ncol;
	coord_t     lc, rc, ur, dr;
	coord_t     wall_row, wall_col;
	logic [6:0] row_sum, col_sum;

	stk_entry_t stk_mem [STACK_DEPTH];
	stk_entry_t stk_rd_q;
	logic       stk_we, stk_re;
	depth_t     stk_waddr, stk_raddr;
	stk_entry_t stk_wdata;

	out_t       out_q, res_d;
	logic       out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= 6'd31;
			height_q    <= 6'd31;
			start_row_q <= 6'd1;
			start_col_q <= 6'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WIDTH:     width_q     <= cfg_data;
				CFG_HEIGHT:    height_q    <= cfg_data;
				CFG_START_ROW: start_row_q <= cfg_data;
				CFG_START_COL: start_col_q <= cfg_data;
			endcase
		end
	end

	// Two-cell move, refused moves leave the target on the walker.
	always_comb begin
		nrow = walker_row_q;
		ncol = walker_col_q;
		unique case (in_data.direction)
			DIR_LEFT:  if (walker_col_q > 6'd2) ncol = walker_col_q - 6'd2;
			DIR_UP:    if (walker_row_q > 6'd2) nrow = walker_row_q - 6'd2;
			DIR_RIGHT: if ((7'(walker_col_q) + 7'd3) < 7'(width_q)) ncol = walker_col_q + 6'd2;
			DIR_DOWN:  if ((7'(walker_row_q) + 7'd3) < 7'(height_q)) nrow = walker_row_q + 6'd2;
		endcase
	end

	// Neighbours for the dead-end test, clamped to the interior.
	assign lc = (walker_col_q > 6'd2) ? walker_col_q - 6'd2 : walker_col_q;
	assign ur = (walker_row_q > 6'd2) ? walker_row_q - 6'd2 : walker_row_q;
	assign rc = ((7'(walker_col_q) + 7'd3) < 7'(width_q)) ? walker_col_q + 6'd2 : walker_col_q;
	assign dr = ((7'(walker_row_q) + 7'd3) < 7'(height_q)) ? walker_row_q + 6'd2 : walker_row_q;

	assign row_sum  = 7'(tgt_row_q) + 7'(walker_row_q);
	assign col_sum  = 7'(tgt_col_q) + 7'(walker_col_q);
	assign wall_row = row_sum[6:1];
	assign wall_col = col_sum[6:1];

	always_comb begin
		cmap_req.kind = en ? ctrl.mem_op : MEM_NONE;
		unique case (ctrl.row_sel)
			ROW_TGT:   cmap_req.row = tgt_row_q;
			ROW_WALL:  cmap_req.row = wall_row;
			ROW_CUR:   cmap_req.row = walker_row_q;
			ROW_UP:    cmap_req.row = ur;
			ROW_DOWN:  cmap_req.row = dr;
			ROW_QUERY: cmap_req.row = qrow_q;
			ROW_START: cmap_req.row = start_row_q;
			default:   cmap_req.row = tgt_row_q;
		endcase
		unique case (ctrl.col_sel)
			COL_TGT:   cmap_req.col = tgt_col_q;
			COL_WALL:  cmap_req.col = wall_col;
			COL_START: cmap_req.col = start_col_q;
			default:   cmap_req.col = tgt_col_q;
		endcase
	end

	assign cond.carve      = !bit_of(rd_word, tgt_col_q) &&
		(depth_q < DEPTH_W'(STACK_DEPTH - 1));
	assign cond.nb_all     = all_q && bit_of(rd_word, walker_col_q);
	assign cond.depth_zero = (depth_q == '0);
	assign cond.done       = done_q;

	always_comb begin
		walker_row_d = walker_row_q;
		walker_col_d = walker_col_q;
		depth_d      = depth_q;
		done_d       = done_q;
		tgt_row_d    = tgt_row_q;
		tgt_col_d    = tgt_col_q;
		qrow_d       = qrow_q;
		qcol_d       = qcol_q;
		all_d        = all_q;
		stk_we       = 1'b0;
		stk_waddr    = depth_t'(depth_q + 1'b1);
		stk_wdata    = {tgt_row_q, tgt_col_q};
		stk_re       = 1'b0;
		stk_raddr    = depth_t'(depth_q - 1'b1);
		if (en) begin
			unique case (ctrl.dp_op)
				DP_NONE: begin
				end
				DP_LOAD: begin
					tgt_row_d = nrow;
					tgt_col_d = ncol;
					qrow_d    = in_data.query_row;
					qcol_d    = in_data.query_col;
				end
				DP_CAP_LR: begin
					all_d = bit_of(rd_word, lc) && bit_of(rd_word, rc);
				end
				DP_CAP_MID: begin
					all_d = all_q && bit_of(rd_word, walker_col_q);
				end
				DP_RESTART: begin
					walker_row_d = start_row_q;
					walker_col_d = start_col_q;
					depth_d      = '0;
					done_d       = 1'b0;
					stk_we       = 1'b1;
					stk_waddr    = '0;
					stk_wdata    = {start_row_q, start_col_q};
				end
				DP_PUSH: begin
					walker_row_d = tgt_row_q;
					walker_col_d = tgt_col_q;
					depth_d      = depth_t'(depth_q + 1'b1);
					stk_we       = 1'b1;
				end
				DP_POP_RD: begin
					depth_d = depth_t'(depth_q - 1'b1);
					stk_re  = 1'b1;
				end
				DP_POP_LD: begin
					walker_row_d = stk_rd_q[2*COORD_W-1:COORD_W];
					walker_col_d = stk_rd_q[COORD_W-1:0];
					done_d       = (depth_q == '0);
				end
				DP_SET_DONE: begin
					done_d = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walker_row_q <= 6'd1;
			walker_col_q <= 6'd1;
			depth_q      <= '0;
			done_q       <= 1'b1;
		end else begin
			walker_row_q <= walker_row_d;
			walker_col_q <= walker_col_d;
			depth_q      <= depth_d;
			done_q       <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		tgt_row_q <= tgt_row_d;
		tgt_col_q <= tgt_col_d;
		qrow_q    <= qrow_d;
		qcol_q    <= qcol_d;
		all_q     <= all_d;
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (stk_re) begin
			stk_rd_q <= stk_mem[stk_raddr];
		end
	end

	always_comb begin
		res_d.action      = ctrl.res;
		res_d.cur_row     = walker_row_d;
		res_d.cur_col     = walker_col_d;
		res_d.wall_row    = (ctrl.res == ACT_CARVED) ? wall_row : '0;
		res_d.wall_col    = (ctrl.res == ACT_CARVED) ? wall_col : '0;
		res_d.stack_depth = DEPTH_OUT_W'(depth_d);
		res_d.done_res    = done_d;
		res_d.cell_open   = (ctrl.res == ACT_CELL_READ) ? bit_of(rd_word, qcol_q) : 1'b0;
	end

	// The sequencer holds a finishing word while a stalled beat is pending,
	// so a load here never overwrites an undelivered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en && ctrl.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctrl.finish) begin
			out_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== src/mcb_checker.sv =====
// ----------------------------------------------------------------------------
// mcb_checker: port-level checks of the maze carver
// Watches the top level's channels, flags bad result beats and double accepts.
// ----------------------------------------------------------------------------
module mcb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input mcb_pkg::out_t                 out_data
);
	import mcb_pkg::*;

	// A stalled result beat must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// One operation at a time: the beat after an accept is always stalled.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second operation accepted back to back");

	// A restart always reports an empty stack and a live walk.
	a_restart_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.action == ACT_RESTARTED) |->
		(out_data.stack_depth == '0) && !out_data.done_res)
		else $error("restart reported a stale walker state");

	// A carved wall lies on the walker's row or column, and the walk is live.
	a_carve_wall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.action == ACT_CARVED) |->
		((out_data.cur_row == out_data.wall_row) ||
		(out_data.cur_col == out_data.wall_col)) && !out_data.done_res)
		else $error("carved wall not adjacent to the walker");

endmodule

bind maze_carver_backtracking_core mcb_checker u_chk (.*);

// ===== tb/carve_check_pkg.sv =====
// ----------------------------------------------------------------------------
// carve_check_pkg: walk tracking and result checking for the maze carver
// Keeps a private copy of the grid bitmap, backtrack trail, walker and
// configuration. It works out the result of every accepted input beat and
// compares the result beats, in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package carve_check_pkg;

	import mcb_pkg::*;

	class walk_tracker;
		int grid_w = 31;
		int grid_h = 31;
		int start_r = 1;
		int start_c = 1;
		int walk_r = 1;
		int walk_c = 1;
		int depth = 0;
		bit walk_done = 1'b1;
		bit open_cells [MAX_SIDE][MAX_SIDE];
		bit [2*COORD_W-1:0] trail [STACK_DEPTH];
		out_t owed_results [$];
		int errors = 0;

		function bit is_open(int r, int c);
			if (r < 0 || c < 0 || r >= MAX_SIDE || c >= MAX_SIDE)
				return 1'b0;
			return open_cells[r][c];
		endfunction

		function void open_at(int r, int c);
			if (r >= 0 && c >= 0 && r < MAX_SIDE && c < MAX_SIDE)
				open_cells[r][c] = 1'b1;
		endfunction

		function void set_reg(cfg_reg_t idx, coord_t v);
			case (idx)
				CFG_WIDTH:     grid_w = int'(v);
				CFG_HEIGHT:    grid_h = int'(v);
				CFG_START_ROW: start_r = int'(v);
				CFG_START_COL: start_c = int'(v);
				default: ;
			endcase
		endfunction

		function out_t advance_walk(in_t beat);
			out_t res;
			int r0, c0, r, c, lc, ur, rc, dr, wr, wc;
			res = '0;
			res.action = ACT_STAYED;
			case (beat.operation)
				OP_RESTART: begin
					foreach (open_cells[i, j])
						open_cells[i][j] = 1'b0;
					walk_r = start_r;
					walk_c = start_c;
					open_at(walk_r, walk_c);
					trail[0] = {coord_t'(walk_r), coord_t'(walk_c)};
					depth = 0;
					walk_done = 1'b0;
					res.action = ACT_RESTARTED;
				end
				OP_READ: begin
					res.cell_open = is_open(int'(beat.query_row), int'(beat.query_col));
					res.action = ACT_CELL_READ;
				end
				OP_STEP: begin
					if (!walk_done) begin
						r0 = walk_r;
						c0 = walk_c;
						r = r0;
						c = c0;
						case (beat.direction)
							DIR_LEFT:  if (c > 2) c -= 2;
							DIR_UP:    if (r > 2) r -= 2;
							DIR_RIGHT: if (c + 3 < grid_w) c += 2;
							DIR_DOWN:  if (r + 3 < grid_h) r += 2;
							default: ;
						endcase
						if (!is_open(r, c) && depth + 1 < STACK_DEPTH) begin
							wr = (r + r0) / 2;
							wc = (c + c0) / 2;
							open_at(r, c);
							open_at(wr, wc);
							depth++;
							trail[depth] = {coord_t'(r), coord_t'(c)};
							walk_r = r;
							walk_c = c;
							res.action = ACT_CARVED;
							res.wall_row = coord_t'(wr);
							res.wall_col = coord_t'(wc);
						end else begin
							// Neighbours on the border are replaced by the walker's own cell.
							lc = (c0 > 2) ? c0 - 2 : c0;
							ur = (r0 > 2) ? r0 - 2 : r0;
							rc = (c0 + 2 < grid_w - 1) ? c0 + 2 : c0;
							dr = (r0 + 2 < grid_h - 1) ? r0 + 2 : r0;
							if (is_open(r0, lc) && is_open(ur, c0) &&
								is_open(r0, rc) && is_open(dr, c0)) begin
								if (depth > 0) begin
									depth--;
									walk_r = int'(trail[depth][2*COORD_W-1:COORD_W]);
									walk_c = int'(trail[depth][COORD_W-1:0]);
								end
								if (depth == 0)
									walk_done = 1'b1;
								res.action = ACT_BACKTRACKED;
							end
						end
					end
				end
				default: ;
			endcase
			res.cur_row = coord_t'(walk_r);
			res.cur_col = coord_t'(walk_c);
			res.stack_depth = DEPTH_OUT_W'(depth);
			res.done_res = walk_done;
			return res;
		endfunction

		function void note_input(in_t beat);
			owed_results = {owed_results, advance_walk(beat)};
		endfunction

		task flag_error(string what);
			$display("%0t ns: MISMATCH %s", $time, what);
			errors++;
		endtask

		task check_field(string name, int got, int want);
			if (got != want)
				flag_error($sformatf("%s got %0d want %0d", name, got, want));
		endtask

		task check_result(out_t got);
			out_t want;
			if (owed_results.size() == 0) begin
				flag_error("result beat arrived with nothing outstanding");
				return;
			end
			want = owed_results.pop_front();
			check_field("action", int'(got.action), int'(want.action));
			check_field("cur_row", int'(got.cur_row), int'(want.cur_row));
			check_field("cur_col", int'(got.cur_col), int'(want.cur_col));
			check_field("wall_row", int'(got.wall_row), int'(want.wall_row));
			check_field("wall_col", int'(got.wall_col), int'(want.wall_col));
			check_field("stack_depth", int'(got.stack_depth), int'(want.stack_depth));
			check_field("done_res", int'(got.done_res), int'(want.done_res));
			check_field("cell_open", int'(got.cell_open), int'(want.cell_open));
		endtask
	endclass

endpackage

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: randomized walk regression for the maze carver core
// Runs a short directed walk through moves, refused moves, backtracking,
// completion and reads, then many random walks on mostly small grids with
// random gaps and stalls on both channels, checking every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

	import mcb_pkg::*;
	import carve_check_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 1900;
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	coord_t cfg_data;

	walk_tracker track;
	int items_sent = 0;
	int results_seen = 0;
	int quiet_send = 0;

	maze_carver_backtracking_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int sender_gap();
		int roll;
		if (quiet_send > 0) begin
			quiet_send--;
			return 0;
		end
		roll = $urandom_range(99, 0);
		if (roll < 2) begin
			quiet_send = $urandom_range(80, 30);
			return 0;
		end
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(3, 1);
		if (roll < 97)
			return $urandom_range(10, 4);
		return $urandom_range(40, 20);
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [1:0] dir, input int qr,
		input int qc);
		in_t beat;
		int gap;
		beat.operation = op;
		beat.direction = dir;
		beat.query_row = coord_t'(qr);
		beat.query_col = coord_t'(qc);
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		do @(posedge clk); while (in_stall);
		track.note_input(beat);
		items_sent++;
	endtask

	// Hold off new input until every outstanding result beat has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (track.owed_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic configure(input int w, input int h, input int sr, input int sc);
		cfg_reg_t regs [4];
		coord_t vals [4];
		regs = '{CFG_WIDTH, CFG_HEIGHT, CFG_START_ROW, CFG_START_COL};
		vals = '{coord_t'(w), coord_t'(h), coord_t'(sr), coord_t'(sc)};
		for (int k = 0; k < 4; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[k];
			cfg_data <= vals[k];
			do @(posedge clk); while (!cfg_ready);
			track.set_reg(regs[k], vals[k]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic random_walk();
		int roll, w, h, sr, sc, budget, after_done, qr, qc;
		roll = $urandom_range(99, 0);
		if (roll < 70) begin
			w = 2 * $urandom_range(7, 2) + 1;
			h = 2 * $urandom_range(7, 2) + 1;
			budget = 250;
		end else if (roll < 82) begin
			w = $urandom_range(1, 0) ? 63 : 2 * $urandom_range(31, 20) + 1;
			h = $urandom_range(1, 0) ? 63 : 2 * $urandom_range(31, 20) + 1;
			budget = 400;
		end else begin
			w = $urandom_range(63, 5);
			h = $urandom_range(63, 5);
			budget = 300;
		end
		if ($urandom_range(99, 0) < 85) begin
			sr = 2 * $urandom_range((h - 3) / 2, 0) + 1;
			sc = 2 * $urandom_range((w - 3) / 2, 0) + 1;
		end else begin
			sr = $urandom_range(61, 1);
			sc = $urandom_range(61, 1);
		end
		drain();
		configure(w, h, sr, sc);
		send_item(OP_RESTART, 2'($urandom_range(3, 0)), $urandom_range(62, 0),
			$urandom_range(62, 0));
		after_done = 0;
		for (int n = 0; n < budget && items_sent < ITEM_TARGET; n++) begin
			if (track.walk_done) begin
				after_done++;
				if (after_done > 2)
					break;
			end
			roll = $urandom_range(99, 0);
			if (roll < 80) begin
				qr = $urandom_range(h - 1 > 62 ? 62 : h - 1, 0);
				qc = $urandom_range(w - 1 > 62 ? 62 : w - 1, 0);
			end else begin
				qr = $urandom_range(62, 0);
				qc = $urandom_range(62, 0);
			end
			roll = $urandom_range(99, 0);
			if (roll < 12)
				send_item(OP_READ, 2'($urandom_range(3, 0)), qr, qc);
			else if (roll < 14)
				send_item(OP_UNUSED, 2'($urandom_range(3, 0)), qr, qc);
			else if (roll == 14)
				send_item(OP_RESTART, 2'($urandom_range(3, 0)), qr, qc);
			else
				send_item(OP_STEP, 2'($urandom_range(3, 0)), qr, qc);
		end
	endtask

	// Result side: random stalls, stretches without stalls, and two long holds
	// taken while the sender is offering so that the core backs up.
	initial begin : result_sink
		int roll, stall_left, holds_done;
		bit stalled;
		stall_left = 0;
		holds_done = 0;
		stalled = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done < 2 && arst_n && in_valid &&
				results_seen >= (holds_done == 0 ? 150 : 1100)) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
				stall_left = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
			end else begin
				roll = $urandom_range(99, 0);
				if (roll < 45) begin
					stalled = 1'b0;
					stall_left = $urandom_range(6, 0);
				end else if (roll < 85) begin
					stalled = 1'b1;
					stall_left = $urandom_range(2, 0);
				end else if (roll < 95) begin
					stalled = 1'b0;
					stall_left = $urandom_range(60, 20);
				end else begin
					stalled = 1'b1;
					stall_left = $urandom_range(40, 10);
				end
			end
			out_stall <= stalled;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			track.check_result(out_data);
			results_seen++;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		track = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset the walk counts as finished and the grid is all wall.
		send_item(OP_STEP, DIR_RIGHT, 0, 0);
		send_item(OP_UNUSED, DIR_DOWN, 62, 62);
		send_item(OP_READ, DIR_LEFT, 0, 0);
		send_item(OP_RESTART, DIR_LEFT, 0, 0);
		send_item(OP_READ, DIR_UP, 1, 1);
		send_item(OP_STEP, DIR_LEFT, 0, 0);
		send_item(OP_STEP, DIR_UP, 0, 0);
		send_item(OP_STEP, DIR_RIGHT, 0, 0);
		send_item(OP_STEP, DIR_DOWN, 0, 0);
		send_item(OP_READ, DIR_RIGHT, 1, 2);

		// Smallest grid: carve three cells, back out to the start, then step once more.
		drain();
		configure(5, 5, 1, 1);
		send_item(OP_RESTART, DIR_UP, 0, 0);
		send_item(OP_STEP, DIR_RIGHT, 0, 0);
		send_item(OP_STEP, DIR_DOWN, 0, 0);
		send_item(OP_STEP, DIR_LEFT, 0, 0);
		send_item(OP_STEP, DIR_UP, 0, 0);
		send_item(OP_STEP, DIR_UP, 0, 0);
		send_item(OP_STEP, DIR_UP, 0, 0);
		send_item(OP_STEP, DIR_RIGHT, 0, 0);

		// A start with every move refused backtracks at depth zero.
		drain();
		configure(5, 5, 2, 2);
		send_item(OP_RESTART, DIR_DOWN, 0, 0);
		send_item(OP_STEP, DIR_DOWN, 0, 0);

		// Largest grid, start in the far corner.
		drain();
		configure(63, 63, 61, 61);
		send_item(OP_RESTART, DIR_RIGHT, 0, 0);
		send_item(OP_STEP, DIR_RIGHT, 0, 0);
		send_item(OP_STEP, DIR_DOWN, 0, 0);
		send_item(OP_STEP, DIR_LEFT, 0, 0);
		send_item(OP_READ, DIR_UP, 61, 60);

		while (items_sent < ITEM_TARGET)
			random_walk();

		drain();
		repeat (20) @(posedge clk);
		if (track.owed_results.size() != 0)
			track.flag_error("result beat never arrived");
		if (track.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== maze_carver_backtracking_core.f =====
src/mcb_pkg.sv
src/mcb_cell_map.sv
src/mcb_sequencer.sv
src/mcb_datapath.sv
src/maze_carver_backtracking_core.sv
src/mcb_checker.sv
tb/carve_check_pkg.sv
tb/tb_top.sv
